// File: rtl/pcp_pkg.sv
// Shared types and constants for the polyline closest point block.
package pcp_pkg;

  localparam int CoordBits  = 24;
  localparam int DiffBits   = CoordBits + 1;
  localparam int ProdBits   = 2 * DiffBits;
  localparam int DotBits    = ProdBits + 1;
  localparam int DistBits   = 50;
  localparam int SegBits    = 16;
  localparam int DivSteps   = CoordBits + 2;
  localparam int DivCntBits = $clog2(DivSteps);
  localparam int RemBits    = DistBits + 2;
  localparam int CfgIdxBits = 1;
  localparam int QueueDepth = 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;

  typedef enum logic [CfgIdxBits-1:0] {
    RegTargetX = 1'b0,
    RegTargetY = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic   first;
    logic   last;
    coord_t px;
    coord_t py;
    coord_t cx;
    coord_t cy;
  } pcp_entry_t;

endpackage

// File: rtl/pcp_front.sv
// Vertex intake: pairs each vertex with its predecessor and queues the word.
module pcp_front import pcp_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vertex_valid_i,
  output logic       vertex_ready_o,
  input  coord_t     vertex_x_i,
  input  coord_t     vertex_y_i,
  input  logic       last_vertex_i,
  output logic       entry_valid_o,
  input  logic       entry_ready_i,
  output pcp_entry_t entry_o
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  pcp_entry_t         mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               have_prev_q;
  coord_t             prev_x_q, prev_y_q;
  logic               push, pop;
  pcp_entry_t         push_word;

  assign vertex_ready_o = (count_q != CntBits'(Depth));
  assign entry_valid_o  = (count_q != '0);
  assign entry_o        = mem_q[rd_ptr_q];
  assign push           = vertex_valid_i && vertex_ready_o;
  assign pop            = entry_valid_o && entry_ready_i;

  always_comb begin
    push_word.first = !have_prev_q;
    push_word.last  = last_vertex_i;
    push_word.px    = prev_x_q;
    push_word.py    = prev_y_q;
    push_word.cx    = vertex_x_i;
    push_word.cy    = vertex_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      have_prev_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q    <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
        prev_x_q    <= vertex_x_i;
        prev_y_q    <= vertex_y_i;
        have_prev_q <= !last_vertex_i;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/pcp_back.sv
// Segment engine: projection, iterative division, distance and running minimum.
module pcp_back import pcp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  coord_t              target_x_i,
  input  coord_t              target_y_i,
  input  logic                entry_valid_i,
  output logic                entry_ready_o,
  input  pcp_entry_t          entry_i,
  output logic                result_valid_o,
  input  logic                result_ready_i,
  output coord_t              closest_x_o,
  output coord_t              closest_y_o,
  output logic [SegBits-1:0]  segment_index_o,
  output logic [DistBits-1:0] min_dist_sq_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_CLS, S_DIV, S_RND,
    S_D0, S_D1, S_D2, S_CMP, S_TAIL, S_EMIT
  } state_e;

  typedef struct packed {
    logic [RemBits-1:0] r;
    logic [1:0]         k;
  } div_step_t;

  function automatic div_step_t div_step(input logic [RemBits-1:0] r, input logic b,
                                         input logic [DistBits-1:0] num,
                                         input logic [DistBits-1:0] den);
    logic [RemBits-1:0] r2, d1, d2;
    div_step_t          res;
    r2 = {r[RemBits-2:0], 1'b0} + (b ? {2'b00, num} : '0);
    d1 = {2'b00, den};
    d2 = {1'b0, den, 1'b0};
    if (r2 >= d2) begin
      res.r = r2 - d2;
      res.k = 2'd2;
    end else if (r2 >= d1) begin
      res.r = r2 - d1;
      res.k = 2'd1;
    end else begin
      res.r = r2;
      res.k = 2'd0;
    end
    return res;
  endfunction

  state_e                  state_q;
  coord_t                  px_q, py_q, cx_q, cy_q, candx_q, candy_q;
  diff_t                   vx_q, vy_q, wx_q, wy_q;
  logic                    last_q, end_q, beyond_q;
  logic signed [ProdBits-1:0] prod_q, acc_q;
  logic signed [DotBits-1:0]  dot_q;
  logic [DistBits-1:0]     den_q, dist_q, best_dist_q;
  logic [RemBits-1:0]      rx_q, ry_q;
  logic [DiffBits-1:0]     qx_q, qy_q;
  logic [DivSteps-1:0]     ax_q, ay_q;
  logic [DivCntBits-1:0]   bit_q;
  logic [SegBits-1:0]      idx_q, seg_count_q, best_idx_q;
  coord_t                  best_x_q, best_y_q;
  logic                    out_valid_q;
  coord_t                  out_x_q, out_y_q;
  logic [SegBits-1:0]      out_idx_q;
  logic [DistBits-1:0]     out_dist_q;

  diff_t                   mul_a, mul_b, dx, dy;
  diff_t                   vx_d, vy_d, wx_d, wy_d;
  logic signed [ProdBits-1:0] prod_d;
  logic signed [DotBits-1:0]  sum_d;
  div_step_t               stx, sty;
  logic [DiffBits-1:0]     qxr, qyr;
  logic signed [DiffBits:0] candx_d, candy_d;

  assign entry_ready_o   = (state_q == S_IDLE);
  assign result_valid_o  = out_valid_q;
  assign closest_x_o     = out_x_q;
  assign closest_y_o     = out_y_q;
  assign segment_index_o = out_idx_q;
  assign min_dist_sq_o   = out_dist_q;

  assign vx_d = {entry_i.cx[CoordBits-1], entry_i.cx} - {entry_i.px[CoordBits-1], entry_i.px};
  assign vy_d = {entry_i.cy[CoordBits-1], entry_i.cy} - {entry_i.py[CoordBits-1], entry_i.py};
  assign wx_d = {target_x_i[CoordBits-1], target_x_i} - {entry_i.px[CoordBits-1], entry_i.px};
  assign wy_d = {target_y_i[CoordBits-1], target_y_i} - {entry_i.py[CoordBits-1], entry_i.py};
  assign dx   = {target_x_i[CoordBits-1], target_x_i} - {candx_q[CoordBits-1], candx_q};
  assign dy   = {target_y_i[CoordBits-1], target_y_i} - {candy_q[CoordBits-1], candy_q};

  always_comb begin
    unique case (state_q)
      S_M0: begin
        mul_a = vx_q;
        mul_b = wx_q;
      end
      S_M1: begin
        mul_a = vy_q;
        mul_b = wy_q;
      end
      S_M2: begin
        mul_a = vx_q;
        mul_b = vx_q;
      end
      S_M3: begin
        mul_a = vy_q;
        mul_b = vy_q;
      end
      S_D0: begin
        mul_a = dx;
        mul_b = dx;
      end
      S_D1: begin
        mul_a = dy;
        mul_b = dy;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign sum_d  = {acc_q[ProdBits-1], acc_q} + {prod_q[ProdBits-1], prod_q};

  assign stx = div_step(rx_q, ax_q[bit_q], dot_q[DistBits-1:0], den_q);
  assign sty = div_step(ry_q, ay_q[bit_q], dot_q[DistBits-1:0], den_q);

  assign qxr = qx_q + DiffBits'({rx_q[RemBits-2:0], 1'b0} >= {2'b00, den_q});
  assign qyr = qy_q + DiffBits'({ry_q[RemBits-2:0], 1'b0} >= {2'b00, den_q});
  assign candx_d = {{2{px_q[CoordBits-1]}}, px_q}
                 + (vx_q[DiffBits-1] ? -$signed({1'b0, qxr}) : $signed({1'b0, qxr}));
  assign candy_d = {{2{py_q[CoordBits-1]}}, py_q}
                 + (vy_q[DiffBits-1] ? -$signed({1'b0, qyr}) : $signed({1'b0, qyr}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seg_count_q <= '0;
      best_dist_q <= '1;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_idx_q  <= '0;
      beyond_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= prod_d;
      if (out_valid_q && result_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (entry_valid_i) begin
            px_q   <= entry_i.px;
            py_q   <= entry_i.py;
            cx_q   <= entry_i.cx;
            cy_q   <= entry_i.cy;
            last_q <= entry_i.last;
            vx_q   <= vx_d;
            vy_q   <= vy_d;
            wx_q   <= wx_d;
            wy_q   <= wy_d;
            if (entry_i.first) begin
              candx_q <= entry_i.cx;
              candy_q <= entry_i.cy;
              idx_q   <= '0;
              end_q   <= 1'b1;
              if (entry_i.last) begin
                state_q <= S_D0;
              end
            end else begin
              idx_q <= seg_count_q;
              end_q <= 1'b0;
              if (seg_count_q != '1) begin
                seg_count_q <= seg_count_q + 1'b1;
              end
              state_q <= (vx_d == '0 && vy_d == '0) ? S_TAIL : S_M0;
            end
          end
        end
        S_M0: state_q <= S_M1;
        S_M1: begin
          acc_q   <= prod_q;
          state_q <= S_M2;
        end
        S_M2: begin
          dot_q   <= sum_d;
          state_q <= S_M3;
        end
        S_M3: begin
          acc_q   <= prod_q;
          state_q <= S_M4;
        end
        S_M4: begin
          den_q   <= sum_d[DistBits-1:0];
          state_q <= S_CLS;
        end
        S_CLS: begin
          if (dot_q[DotBits-1] || dot_q == '0) begin
            beyond_q <= 1'b0;
            candx_q  <= px_q;
            candy_q  <= py_q;
            state_q  <= S_D0;
          end else if (dot_q[DistBits-1:0] >= den_q) begin
            beyond_q <= 1'b1;
            state_q  <= S_TAIL;
          end else begin
            beyond_q <= 1'b0;
            ax_q     <= vx_q[DiffBits-1] ? DivSteps'(-vx_q) : DivSteps'(vx_q);
            ay_q     <= vy_q[DiffBits-1] ? DivSteps'(-vy_q) : DivSteps'(vy_q);
            rx_q     <= '0;
            ry_q     <= '0;
            qx_q     <= '0;
            qy_q     <= '0;
            bit_q    <= DivCntBits'(DivSteps - 1);
            state_q  <= S_DIV;
          end
        end
        S_DIV: begin
          rx_q <= stx.r;
          ry_q <= sty.r;
          qx_q <= {qx_q[DiffBits-2:0], 1'b0} + DiffBits'(stx.k);
          qy_q <= {qy_q[DiffBits-2:0], 1'b0} + DiffBits'(sty.k);
          if (bit_q == '0) begin
            state_q <= S_RND;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_RND: begin
          candx_q <= candx_d[CoordBits-1:0];
          candy_q <= candy_d[CoordBits-1:0];
          state_q <= S_D0;
        end
        S_D0: state_q <= S_D1;
        S_D1: begin
          acc_q   <= prod_q;
          state_q <= S_D2;
        end
        S_D2: begin
          dist_q  <= sum_d[DistBits-1:0];
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (dist_q < best_dist_q) begin
            best_dist_q <= dist_q;
            best_x_q    <= candx_q;
            best_y_q    <= candy_q;
            best_idx_q  <= idx_q;
          end
          state_q <= S_TAIL;
        end
        S_TAIL: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (beyond_q && !end_q) begin
            candx_q <= cx_q;
            candy_q <= cy_q;
            end_q   <= 1'b1;
            state_q <= S_D0;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || result_ready_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= best_x_q;
            out_y_q     <= best_y_q;
            out_idx_q   <= best_idx_q;
            out_dist_q  <= best_dist_q;
            seg_count_q <= '0;
            best_dist_q <= '1;
            best_x_q    <= '0;
            best_y_q    <= '0;
            best_idx_q  <= '0;
            beyond_q    <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/polyline_closest_point.sv
// Closest point on a polyline to a configured target point.
//
// Vertices enter on the vertex channel (valid/ready), one word per vertex;
// last_vertex_i closes the polyline. One result word per polyline leaves on
// the result channel (valid/ready) with the closest point, its segment index
// and the squared distance. The target point is written through the cfg port
// (index 0 = x, index 1 = y); the user is to write it only while the block is
// idle, which the block does not enforce. A zero-length segment goes straight
// to the tail check; other segments run the products and a classify step,
// then, unless the target lies beyond the end, the 26-step divider pair and a
// rounding step where a projection is needed, and the distance steps. The
// last vertex adds an emit step, and the end point test if needed. A two word
// queue ahead of the engine keeps accepting vertices while it works.
// Reset clears the queue, the polyline state and the target point; the
// block is ready in the first cycle after reset.
// A stalled result holds in the output register; the engine keeps working
// on the next polyline and waits only when its next result is due.
module polyline_closest_point import pcp_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  coord_t                cfg_data_i,
  input  logic                  vertex_valid_i,
  output logic                  vertex_ready_o,
  input  coord_t                vertex_x_i,
  input  coord_t                vertex_y_i,
  input  logic                  last_vertex_i,
  output logic                  result_valid_o,
  input  logic                  result_ready_i,
  output coord_t                closest_x_o,
  output coord_t                closest_y_o,
  output logic [SegBits-1:0]    segment_index_o,
  output logic [DistBits-1:0]   min_dist_sq_o
);

  coord_t     target_x_q, target_y_q;
  logic       entry_valid, entry_ready;
  pcp_entry_t entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q <= '0;
      target_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegTargetX: target_x_q <= cfg_data_i;
        RegTargetY: target_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pcp_front #(
    .Depth(QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vertex_valid_i(vertex_valid_i),
    .vertex_ready_o(vertex_ready_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .last_vertex_i (last_vertex_i),
    .entry_valid_o (entry_valid),
    .entry_ready_i (entry_ready),
    .entry_o       (entry)
  );

  pcp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .target_x_i     (target_x_q),
    .target_y_i     (target_y_q),
    .entry_valid_i  (entry_valid),
    .entry_ready_o  (entry_ready),
    .entry_i        (entry),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .closest_x_o    (closest_x_o),
    .closest_y_o    (closest_y_o),
    .segment_index_o(segment_index_o),
    .min_dist_sq_o  (min_dist_sq_o)
  );

endmodule

// File: rtl/pcp_checker.sv
// Port-level checks for the polyline closest point block, bound to the top.
module pcp_checker import pcp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                result_valid_o,
  input logic                result_ready_i,
  input coord_t              closest_x_o,
  input coord_t              closest_y_o,
  input logic [SegBits-1:0]  segment_index_o,
  input logic [DistBits-1:0] min_dist_sq_o
);

  localparam logic [DistBits-1:0] MaxDist = DistBits'(64'd1 << (2 * CoordBits + 1));

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o && $stable(closest_x_o)
      && $stable(closest_y_o) && $stable(segment_index_o) && $stable(min_dist_sq_o))
    else $error("result word changed while stalled");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> min_dist_sq_o <= MaxDist)
    else $error("distance sentinel leaked to result");

  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !result_valid_o)
    else $error("result valid right after reset");

  a_drop_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(result_valid_o) |-> $past(result_ready_i))
    else $error("result dropped without handshake");

endmodule

bind polyline_closest_point pcp_checker u_pcp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i),
  .closest_x_o    (closest_x_o),
  .closest_y_o    (closest_y_o),
  .segment_index_o(segment_index_o),
  .min_dist_sq_o  (min_dist_sq_o)
);
